>>> hw/rtl/dqp_pkg.sv
package dqp_pkg;

    // Longest field, prefix included
    localparam int unsigned MAX_FIELD_CHARS = 11;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned OCTET_W  = 9;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned INDEX_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_UC_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'h78;

    localparam logic [OCTET_W-1:0] OCTET_SAT = 9'd256;
    localparam logic [INDEX_W-1:0] LAST_FIELD = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_CHARS = COUNT_W'(MAX_FIELD_CHARS);

    typedef struct packed {
        logic [ADDR_W-1:0]  partial_address;
        logic [OCTET_W-1:0] octet_value;
        logic [COUNT_W-1:0] field_chars;
        logic [INDEX_W-1:0] field_index;
        logic               hex_mode;
        logic               error_seen;
    } dqp_state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic              status;
    } dqp_result_t;

endpackage

>>> hw/rtl/dqp_step.sv
module dqp_step (
    input  logic [7:0]          char_in,
    input  dqp_pkg::dqp_state_t state_cur,
    output dqp_pkg::dqp_state_t state_next,
    output dqp_pkg::dqp_result_t result
);
    import dqp_pkg::*;

    logic              digit_ok;
    logic [3:0]        digit;
    logic              field_good;
    logic              is_x;
    logic [12:0]       scaled;
    logic [12:0]       accum;
    logic [OCTET_W-1:0] octet_upd;
    logic [ADDR_W-1:0] octet_placed;

    // Decode one digit in the current base
    always_comb begin
        digit_ok = 1'b0;
        digit    = 4'd0;
        if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
            digit_ok = 1'b1;
            digit    = char_in[3:0];
        end else if (state_cur.hex_mode &&
                     ((char_in >= CHAR_LC_A && char_in <= CHAR_LC_F) ||
                      (char_in >= CHAR_UC_A && char_in <= CHAR_UC_F))) begin
            digit_ok = 1'b1;
            digit    = char_in[3:0] + 4'd9;
        end
    end

    assign is_x = (char_in == CHAR_LC_X) || (char_in == CHAR_UC_X);

    assign field_good = (state_cur.field_chars != '0) &&
                        !(state_cur.hex_mode && state_cur.field_chars == 4'd2) &&
                        !state_cur.octet_value[OCTET_W-1];

    // Shift-add for times ten, plain shift for times sixteen
    always_comb begin
        if (state_cur.hex_mode) begin
            scaled = {state_cur.octet_value, 4'b0000};
        end else begin
            scaled = {1'b0, state_cur.octet_value, 3'b000} +
                     {3'b000, state_cur.octet_value, 1'b0};
        end
        accum     = scaled + {9'd0, digit};
        octet_upd = (accum > 13'(OCTET_SAT)) ? OCTET_SAT : accum[OCTET_W-1:0];
    end

    always_comb begin
        unique case (state_cur.field_index)
            2'd0:    octet_placed = {state_cur.octet_value[7:0], 24'd0};
            2'd1:    octet_placed = {8'd0, state_cur.octet_value[7:0], 16'd0};
            2'd2:    octet_placed = {16'd0, state_cur.octet_value[7:0], 8'd0};
            default: octet_placed = {24'd0, state_cur.octet_value[7:0]};
        endcase
    end

    always_comb begin
        state_next     = state_cur;
        result.valid   = 1'b0;
        result.address = '0;
        result.status  = 1'b1;
        priority if (char_in == CHAR_NUL) begin
            result.valid = 1'b1;
            if (!state_cur.error_seen) begin
                if (state_cur.field_index == '0 && state_cur.field_chars == '0) begin
                    result.status = 1'b0;
                end else if (state_cur.field_index == LAST_FIELD && field_good) begin
                    result.address = state_cur.partial_address | octet_placed;
                    result.status  = 1'b0;
                end
            end
            state_next = '0;
        end else if (state_cur.error_seen) begin
            state_next = state_cur;
        end else if (char_in == CHAR_DOT) begin
            if (!field_good || state_cur.field_index == LAST_FIELD) begin
                state_next.error_seen = 1'b1;
            end else begin
                state_next.partial_address = state_cur.partial_address | octet_placed;
                state_next.field_index     = state_cur.field_index + 2'd1;
                state_next.octet_value     = '0;
                state_next.field_chars     = '0;
                state_next.hex_mode        = 1'b0;
            end
        end else if (state_cur.field_chars >= MAX_CHARS) begin
            state_next.error_seen = 1'b1;
        end else if (is_x && state_cur.field_chars == 4'd1 &&
                     state_cur.octet_value == '0 && !state_cur.hex_mode) begin
            state_next.hex_mode    = 1'b1;
            state_next.field_chars = state_cur.field_chars + 4'd1;
        end else if (!digit_ok) begin
            state_next.error_seen = 1'b1;
        end else begin
            state_next.octet_value = octet_upd;
            state_next.field_chars = state_cur.field_chars + 4'd1;
        end
    end

endmodule

>>> hw/rtl/dotted_quad_ipv4_parser_top.sv
// Dotted-quad IPv4 text parser, one ASCII character per transfer.
// A terminator's result passes through the input register, then the state update
// into the result register.
// Throughput: one character per cycle while the result register is empty or m_tready is high.
// Reset: aresetn is synchronous and active low; it clears the parse state
// and both valid flags, so no result is pending after reset.
module dotted_quad_ipv4_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address
    output logic        m_tuser    // [0] status
);
    import dqp_pkg::*;

    // Input register stage
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;

    // Parse state
    dqp_state_t  state_reg, state_next;
    dqp_state_t  step_state;
    dqp_result_t step_result;

    // Result register stage
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_status_reg, out_status_next;

    logic advance;

    // Advance the held character when the result register can take its outcome
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dqp_step u_step (
        .char_in    (in_char_reg),
        .state_cur  (state_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_char_next  = s_tdata;
        end
    end

    always_comb begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        if (advance) begin
            state_next      = step_state;
            out_valid_next  = step_result.valid;
            out_addr_next   = step_result.address;
            out_status_next = step_result.status;
        end else if (m_tready) begin
            // Drop the result once it has been taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        in_char_reg    <= in_char_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    // A malformed string always reports a zero address
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result carries a non-zero address");

    // A processed terminator leaves the parse state fully cleared
    a_term_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_char_reg == CHAR_NUL) |=> (state_reg == '0))
        else $error("parse state not cleared after terminator");

    // The field length never exceeds its limit
    a_chars_max: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.field_chars <= MAX_CHARS)
        else $error("field character count beyond limit");

    // The octet accumulator saturates at 256
    a_octet_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.octet_value <= OCTET_SAT)
        else $error("octet accumulator beyond saturation value");

    // A result only appears after a terminator has been processed
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance && in_char_reg == CHAR_NUL))
        else $error("result without terminator");

endmodule

>>> bench/dqp_parse_checker.sv
module dqp_parse_checker
    import dqp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,    // [7:0] char_in
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [ADDR_W-1:0] m_tdata,    // [31:0] address
    input  logic              m_tuser,    // [0] status
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic              status;
    } parse_result_t;

    parse_result_t expected_addr_q[$];

    // Shadow parse state
    logic [ADDR_W-1:0]  addr_acc;
    logic [OCTET_W-1:0] octet_acc;
    logic [COUNT_W-1:0] chars_in_field;
    logic [INDEX_W-1:0] field_num;
    logic               hex_field;
    logic               malformed;

    function automatic int digit_value(input logic [CHAR_W-1:0] c, input logic hex);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return int'(c - CHAR_ZERO);
        end
        if (hex && c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            return int'(c - CHAR_LC_A) + 10;
        end
        if (hex && c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            return int'(c - CHAR_UC_A) + 10;
        end
        return -1;
    endfunction

    // Field has digits and fits in one octet
    function automatic logic field_ok();
        if (chars_in_field == 0) begin
            return 1'b0;
        end
        if (hex_field && chars_in_field == 2) begin
            return 1'b0;
        end
        return octet_acc <= 255;
    endfunction

    task automatic clear_field();
        octet_acc      = '0;
        chars_in_field = '0;
        hex_field      = 1'b0;
    endtask

    task automatic clear_parse();
        clear_field();
        addr_acc  = '0;
        field_num = '0;
        malformed = 1'b0;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        int            d;
        logic [31:0]   v;
        parse_result_t r;
        if (c == CHAR_NUL) begin
            r.address = '0;
            r.status  = 1'b1;
            if (!malformed) begin
                if (field_num == 0 && chars_in_field == 0) begin
                    r.status = 1'b0;
                end else if (field_num == LAST_FIELD && field_ok()) begin
                    r.address = addr_acc | ADDR_W'(octet_acc);
                    r.status  = 1'b0;
                end
            end
            expected_addr_q.push_back(r);
            clear_parse();
        end else if (malformed) begin
            // drop everything up to the terminator
        end else if (c == CHAR_DOT) begin
            if (!field_ok() || field_num == LAST_FIELD) begin
                malformed = 1'b1;
            end else begin
                addr_acc  = addr_acc
                          | (ADDR_W'(octet_acc[7:0]) << (8 * (LAST_FIELD - field_num)));
                field_num = field_num + 1'b1;
                clear_field();
            end
        end else if (chars_in_field >= MAX_CHARS) begin
            malformed = 1'b1;
        end else if ((c == CHAR_LC_X || c == CHAR_UC_X) && chars_in_field == 1
                     && octet_acc == 0 && !hex_field) begin
            hex_field      = 1'b1;
            chars_in_field = chars_in_field + 1'b1;
        end else begin
            d = digit_value(c, hex_field);
            if (d < 0) begin
                malformed = 1'b1;
            end else begin
                v = octet_acc * (hex_field ? 16 : 10) + d;
                octet_acc      = (v > OCTET_SAT) ? OCTET_SAT : v[OCTET_W-1:0];
                chars_in_field = chars_in_field + 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            clear_parse();
            expected_addr_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_addr_q.size() == 0) begin
                    $error("unexpected result transfer: address %h status %0b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_addr_q.pop_front();
                    if (m_tdata !== want.address) begin
                        $error("address: expected %h, actual %h", want.address, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0b, actual %0b", want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata);
            end
        end
        pending = expected_addr_q.size();
    end

endmodule

>>> bench/dotted_quad_ipv4_parser_top_test.sv
module dotted_quad_ipv4_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dqp_pkg::*;

    localparam int CHAR_TARGET = 1700;     // characters in the random part
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
    localparam int DRAIN_CYCLES = 10;      // input and result registers plus margin

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata = '0;       // [7:0] char_in
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [ADDR_W-1:0] m_tdata;            // [31:0] address
    logic              m_tuser;            // [0] status

    int fail_count;
    int pending;
    int send_idle_pct = 36;
    int recv_idle_pct = 83;
    int chars_sent = 0;
    int cycles = 0;

    // Text of the string being sent, terminator included
    logic [CHAR_W-1:0] text_q[$];

    initial begin
        forever #4 aclk = ~aclk;
    end

    dotted_quad_ipv4_parser_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dqp_parse_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: abandon a hung run
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: stall at random, once per cycle, with the current idle rate
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one character; idle first at random, then hold it until the transfer.
    // Valid is left high afterwards so back-to-back characters never toggle it.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_char(text_q[i]);
        end
    endtask

    task automatic queue_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
        text_q.push_back(CHAR_NUL);
    endtask

    function automatic int count_digits(input int unsigned v, input bit hex);
        int n;
        n = 0;
        do begin
            v = hex ? v / 16 : v / 10;
            n++;
        end while (v != 0);
        return n;
    endfunction

    // Append one field: optional 0x/0X prefix, pad zeros, then digits in mixed case
    task automatic push_number(input int unsigned v, input bit hex, input int pad);
        logic [CHAR_W-1:0] digs[$];
        int unsigned       d;
        if (hex) begin
            text_q.push_back(CHAR_ZERO);
            text_q.push_back($urandom_range(1) ? CHAR_LC_X : CHAR_UC_X);
        end
        repeat (pad) text_q.push_back(CHAR_ZERO);
        do begin
            d = hex ? v % 16 : v % 10;
            if (d < 10) begin
                digs.push_front(CHAR_ZERO + CHAR_W'(d));
            end else begin
                digs.push_front(($urandom_range(1) ? CHAR_LC_A : CHAR_UC_A) + CHAR_W'(d - 10));
            end
            v = hex ? v / 16 : v / 10;
        end while (v != 0);
        foreach (digs[i]) text_q.push_back(digs[i]);
    endtask

    // Character that sits on a boundary of the digit and prefix rules
    function automatic logic [CHAR_W-1:0] edge_char();
        case ($urandom_range(7))
            0:       return CHAR_LC_X;
            1:       return CHAR_UC_X;
            2:       return CHAR_DOT;
            3:       return CHAR_LC_F + 1'b1;
            4:       return CHAR_ZERO - 1'b1;
            5:       return CHAR_NINE + 1'b1;
            6:       return CHAR_UC_A - 1'b1;
            default: return CHAR_UC_F;
        endcase
    endfunction

    // Build one string. Half are well-formed addresses with random content; the
    // rest break one rule each, or are empty or plain noise.
    task automatic build_text();
        int unsigned pick;
        int unsigned nfields;
        int unsigned bad_field;
        int unsigned v;
        int unsigned pos;
        int          maxpad;
        int          pad;
        bit          hex;
        text_q.delete();
        pick = $urandom_range(99);
        if (pick < 4) begin
            // empty string: terminator alone
        end else if (pick < 10) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(CHAR_W'($urandom_range(1, 255)));
        end else begin
            nfields = 4;
            if (pick >= 60 && pick < 64) begin
                nfields = $urandom_range(1, 3);
            end else if (pick >= 64 && pick < 68) begin
                nfields = 5;
            end
            bad_field = $urandom_range(nfields - 1);
            for (int f = 0; f < nfields; f++) begin
                if (f != 0) begin
                    text_q.push_back(CHAR_DOT);
                end
                hex = ($urandom_range(2) == 0);
                if ($urandom_range(7) == 0) begin
                    v = 255;
                end else if ($urandom_range(7) == 0) begin
                    v = 0;
                end else begin
                    v = $urandom_range(255);
                end
                if (f == bad_field) begin
                    if (pick >= 68 && pick < 74) begin
                        v = hex ? $urandom_range(256, 32'hFFFFF) : $urandom_range(256, 99999);
                    end else if (pick >= 74 && pick < 78) begin
                        // prefix with no digits
                        text_q.push_back(CHAR_ZERO);
                        text_q.push_back($urandom_range(1) ? CHAR_LC_X : CHAR_UC_X);
                        continue;
                    end else if (pick >= 78 && pick < 81) begin
                        continue;
                    end
                end
                maxpad = (hex ? 9 : 11) - count_digits(v, hex);
                if (maxpad < 0) begin
                    maxpad = 0;
                end
                if ($urandom_range(9) == 0) begin
                    pad = maxpad;
                end else begin
                    pad = $urandom_range(0, (maxpad < 2) ? maxpad : 2);
                end
                if (f == bad_field && pick >= 81 && pick < 86) begin
                    pad = maxpad + $urandom_range(1, 3);
                end
                push_number(v, hex, pad);
            end
            if (pick >= 86 && pick < 89) begin
                text_q.push_back(CHAR_DOT);
            end
            if (pick >= 89 && text_q.size() > 0) begin
                pos = $urandom_range(text_q.size() - 1);
                text_q[pos] = (pick < 94) ? CHAR_W'($urandom_range(1, 255)) : edge_char();
            end
        end
        text_q.push_back(CHAR_NUL);
    endtask

    initial begin
        // Hold reset at the start, then release it once for good
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings: empty string, hex prefixes of both cases with mixed-case
        // digits and the field extremes, a top-bit character, a prefix with no
        // digits, and a trailing dot that also leaves the address short of fields.
        queue_text("");
        send_text();
        queue_text("0xfF.9.0X0.255");
        send_text();
        text_q = '{8'hFF, CHAR_NUL};
        send_text();
        queue_text("0x");
        send_text();
        queue_text("9.");
        send_text();

        // Random strings over three idling regimes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (chars_sent < (phase + 1) * CHAR_TARGET / 3) begin
                build_text();
                send_text();
            end
        end

        // Drop valid, let the checker see the last transfer, then drain results
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
